// ----- design/lbs_pkg.sv -----
// Shared constants, types and the level-to-amplitude table of the LED bar scanner.
`timescale 1ns / 1ps

package lbs_pkg;

   // Bar geometry
   localparam int CLUSTERS         = 3;
   localparam int BARS_PER_CLUSTER = 5;
   localparam int BAR_COUNT        = CLUSTERS * BARS_PER_CLUSTER;
   localparam int BAR_W            = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
   localparam int CLUSTER_W        = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int SEG_W            = (BARS_PER_CLUSTER > 1) ? $clog2(BARS_PER_CLUSTER) : 1;
   localparam int MIDDLE_CLUSTER   = (CLUSTERS - 1) / 2;
   localparam int CENTRE_SEG       = (BARS_PER_CLUSTER - 1) / 2;
   // bloom works in half bars: e*(c+1) - |i-c| doubled
   localparam int BLOOM_SCALE      = BARS_PER_CLUSTER + 1;
   localparam int BLOOM_OFF_MAX    = BARS_PER_CLUSTER - 1;

   // Field widths
   localparam int ACTION_W      = 2;
   localparam int LEVEL_W       = 8;
   localparam int BAR_INDEX_W   = 4;
   localparam int OPA_W         = 8;
   localparam int STEP_W        = 20;
   localparam int COEF_W        = 17;
   localparam int EYE_W         = 20;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 20;
   localparam int PROD_W        = 2 * COEF_W;
   // signed brightness work width
   localparam int B_W           = 24;

   // Fixed-point constants
   localparam int Q16_ONE       = 65536;
   localparam int Q16_HALF      = 32768;
   localparam int CENTRE_FLOOR  = 11796;
   localparam int ENV_MAX       = 131071;
   localparam int EYE_LAST      = (BAR_COUNT - 1) * Q16_ONE;
   localparam int LEVEL_FULL    = 255;
   localparam int LEVEL_COUNT   = 256;

   // Register reset values
   localparam logic [STEP_W-1:0] SCAN_STEP_RST     = 20'd33640;
   localparam logic [OPA_W-1:0]  FLOOR_OPACITY_RST = 8'd28;
   localparam logic [COEF_W-1:0] OUTER_ATTACK_RST  = 17'd36045;
   localparam logic [COEF_W-1:0] CENTRE_ATTACK_RST = 17'd49152;
   localparam logic [COEF_W-1:0] OUTER_DECAY_RST   = 17'd6554;
   localparam logic [COEF_W-1:0] CENTRE_DECAY_RST  = 17'd11796;
   localparam logic [COEF_W-1:0] OUTER_GAIN_RST    = 17'd52429;
   localparam logic [COEF_W-1:0] CENTRE_GAIN_RST   = 17'd65536;

   // Request action codes (the spare code runs as an idle frame)
   typedef enum logic [ACTION_W-1:0] {
      ACT_IDLE    = 2'd0,
      ACT_MIC     = 2'd1,
      ACT_SPEAKER = 2'd2
   } action_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SCAN_STEP     = 3'd0,
      REG_FLOOR_OPACITY = 3'd1,
      REG_OUTER_ATTACK  = 3'd2,
      REG_CENTRE_ATTACK = 3'd3,
      REG_OUTER_DECAY   = 3'd4,
      REG_CENTRE_DECAY  = 3'd5,
      REG_OUTER_GAIN    = 3'd6,
      REG_CENTRE_GAIN   = 3'd7
   } reg_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EYE,
      S_TARGET,
      S_STEP,
      S_ENV,
      S_BRIGHT,
      S_EMIT
   } state_type;

   typedef logic [COEF_W-1:0] sqrt_table_type [LEVEL_COUNT];

   // floor(sqrt(floor(L * 2^32 / 255))) for every level, built at elaboration
   function automatic sqrt_table_type build_sqrt_table();
      sqrt_table_type tbl;
      logic [63:0]    x;
      logic [63:0]    r;
      logic [63:0]    b;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         x = (64'(l) << 32) / LEVEL_FULL;
         r = '0;
         for (int k = 31; k >= 0; k--) begin
            b = 64'd1 << (2 * k);
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
         end
         tbl[l] = COEF_W'(r);
      end
      return tbl;
   endfunction

   localparam sqrt_table_type SQRT_TABLE = build_sqrt_table();

endpackage

// ----- design/lbs_if.sv -----
// Handshake channels of the LED bar scanner: request, response and register write.
`timescale 1ns / 1ps

interface lbs_req_if;
   logic                        valid;
   logic                        ready;
   logic [lbs_pkg::ACTION_W-1:0] action;
   logic [lbs_pkg::LEVEL_W-1:0]  mic_level;
   logic [lbs_pkg::LEVEL_W-1:0]  speaker_level;
   modport source (output valid, action, mic_level, speaker_level, input ready);
   modport sink   (input valid, action, mic_level, speaker_level, output ready);
endinterface

interface lbs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lbs_pkg::BAR_INDEX_W-1:0] bar_index;
   logic [lbs_pkg::OPA_W-1:0]       opacity;
   logic                           changed;
   logic                           last;
   modport source (output valid, bar_index, opacity, changed, last, input ready);
   modport sink   (input valid, bar_index, opacity, changed, last, output ready);
endinterface

interface lbs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lbs_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [lbs_pkg::CSR_DATA_W-1:0]  wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- design/led_bar_scanner_and_level_meter.sv -----
// Top level of the LED bar scanner and level meter: sequencer, shared multiplier, state.
`timescale 1ns / 1ps

// Each request is one frame tick and yields one response per bar, bars in index order,
// the final one flagged last. An idle frame moves the bouncing eye and clears the
// cluster envelopes; a voice frame follows the selected loudness with each cluster's
// envelope and blooms it outward from the cluster centre. All products run through one
// registered 17x17 multiplier under a small sequencer: an idle frame runs an eye step,
// then a brightness and an emit state per bar; a voice frame runs target, step and
// envelope states per cluster, then a brightness and an emit state per bar. The emit state
// waits while the response side stalls. The final response sits in an output register,
// so the next request is taken while it waits. Register writes are accepted every cycle.
module led_bar_scanner_and_level_meter (
   input  logic          clock,
   input  logic          reset,
   lbs_req_if.sink       req_bus,
   lbs_rsp_if.source     rsp_bus,
   lbs_csr_if.sink       csr_bus
);

   // Configuration registers
   logic [lbs_pkg::STEP_W-1:0] scan_step_ff;
   logic [lbs_pkg::OPA_W-1:0]  floor_opacity_ff;
   logic [lbs_pkg::COEF_W-1:0] outer_attack_ff;
   logic [lbs_pkg::COEF_W-1:0] centre_attack_ff;
   logic [lbs_pkg::COEF_W-1:0] outer_decay_ff;
   logic [lbs_pkg::COEF_W-1:0] centre_decay_ff;
   logic [lbs_pkg::COEF_W-1:0] outer_gain_ff;
   logic [lbs_pkg::COEF_W-1:0] centre_gain_ff;

   // Sequencer and counters
   lbs_pkg::state_type             state_ff, state_in;
   logic [lbs_pkg::BAR_W-1:0]      bar_ff, bar_in;
   logic [lbs_pkg::CLUSTER_W-1:0]  clus_ff, clus_in;
   logic [lbs_pkg::SEG_W-1:0]      seg_ff, seg_in;
   logic                           voice_ff, voice_in;
   logic [lbs_pkg::COEF_W-1:0]     amp_ff, amp_in;
   logic                           up_ff, up_in;

   // Shared multiplier
   logic [lbs_pkg::COEF_W-1:0]     mul_a, mul_b;
   logic                           mul_en;
   logic [lbs_pkg::PROD_W-1:0]     mul_ff;
   logic [lbs_pkg::PROD_W:0]       mul_round;

   // Frame state
   logic [lbs_pkg::EYE_W-1:0]      eye_ff, eye_in;
   logic                           down_ff, down_in;
   logic                           eye_we;
   logic [lbs_pkg::COEF_W-1:0]     env_ff [lbs_pkg::CLUSTERS];
   logic [lbs_pkg::COEF_W-1:0]     env_in;
   logic                           env_we, env_clear;
   logic [lbs_pkg::OPA_W-1:0]      prev_ff [lbs_pkg::BAR_COUNT];
   logic                           emit;

   // Output register
   logic                           rsp_valid_ff;
   logic [lbs_pkg::BAR_INDEX_W-1:0] rsp_bar_ff;
   logic [lbs_pkg::OPA_W-1:0]      rsp_opa_ff;
   logic                           rsp_changed_ff;
   logic                           rsp_last_ff;
   logic                           out_free;

   // Datapath values
   logic                           mid;
   logic [lbs_pkg::COEF_W-1:0]     e_cur;
   logic [lbs_pkg::COEF_W-1:0]     target;
   logic [lbs_pkg::COEF_W+1:0]     env_step;
   logic [lbs_pkg::COEF_W+2:0]     env_sum;
   logic signed [lbs_pkg::EYE_W+1:0] eye_p;
   logic [lbs_pkg::EYE_W:0]        bar_pos, eye_dist;
   logic [lbs_pkg::EYE_W:0]        dist_q;
   logic [lbs_pkg::SEG_W:0]        seg2, off_v;
   logic signed [lbs_pkg::B_W-1:0] b_idle, b2, b2_inc, b_voice, b_sel;
   logic [lbs_pkg::COEF_W-1:0]     b_clamp;
   logic [lbs_pkg::OPA_W-1:0]      opa;
   logic                           bar_is_last;
   logic                           env_nonzero;
   lbs_pkg::action_type            req_action;

   // Register writes, always accepted
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_step_ff     <= lbs_pkg::SCAN_STEP_RST;
         floor_opacity_ff <= lbs_pkg::FLOOR_OPACITY_RST;
         outer_attack_ff  <= lbs_pkg::OUTER_ATTACK_RST;
         centre_attack_ff <= lbs_pkg::CENTRE_ATTACK_RST;
         outer_decay_ff   <= lbs_pkg::OUTER_DECAY_RST;
         centre_decay_ff  <= lbs_pkg::CENTRE_DECAY_RST;
         outer_gain_ff    <= lbs_pkg::OUTER_GAIN_RST;
         centre_gain_ff   <= lbs_pkg::CENTRE_GAIN_RST;
      end else if (csr_bus.valid) begin
         unique case (lbs_pkg::reg_index_type'(csr_bus.reg_index))
            lbs_pkg::REG_SCAN_STEP:     scan_step_ff     <= csr_bus.wdata[lbs_pkg::STEP_W-1:0];
            lbs_pkg::REG_FLOOR_OPACITY: floor_opacity_ff <= csr_bus.wdata[lbs_pkg::OPA_W-1:0];
            lbs_pkg::REG_OUTER_ATTACK:  outer_attack_ff  <= csr_bus.wdata[lbs_pkg::COEF_W-1:0];
            lbs_pkg::REG_CENTRE_ATTACK: centre_attack_ff <= csr_bus.wdata[lbs_pkg::COEF_W-1:0];
            lbs_pkg::REG_OUTER_DECAY:   outer_decay_ff   <= csr_bus.wdata[lbs_pkg::COEF_W-1:0];
            lbs_pkg::REG_CENTRE_DECAY:  centre_decay_ff  <= csr_bus.wdata[lbs_pkg::COEF_W-1:0];
            lbs_pkg::REG_OUTER_GAIN:    outer_gain_ff    <= csr_bus.wdata[lbs_pkg::COEF_W-1:0];
            lbs_pkg::REG_CENTRE_GAIN:   centre_gain_ff   <= csr_bus.wdata[lbs_pkg::COEF_W-1:0];
         endcase
      end
   end

   // Shared datapath terms
   assign req_action  = lbs_pkg::action_type'(req_bus.action);
   assign mid         = (clus_ff == lbs_pkg::CLUSTER_W'(lbs_pkg::MIDDLE_CLUSTER));
   assign e_cur       = env_ff[clus_ff];
   assign mul_round   = {1'b0, mul_ff} + (lbs_pkg::PROD_W + 1)'(lbs_pkg::Q16_HALF);
   assign target      = mul_round[lbs_pkg::COEF_W+15:16];
   assign env_step    = mul_round[lbs_pkg::PROD_W:16];
   assign opa         = mul_round[23:16] + floor_opacity_ff;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign bar_is_last = (bar_ff == lbs_pkg::BAR_W'(lbs_pkg::BAR_COUNT - 1));

   // Eye step: move, then clamp at the ends and turn
   assign eye_p = down_ff
      ? $signed({2'b00, eye_ff}) - $signed({2'b00, scan_step_ff})
      : $signed({2'b00, eye_ff}) + $signed({2'b00, scan_step_ff});

   // Idle brightness: one minus a quarter of the distance to the eye
   assign bar_pos  = (lbs_pkg::EYE_W + 1)'(bar_ff) << 16;
   assign eye_dist = (bar_pos >= {1'b0, eye_ff}) ? bar_pos - {1'b0, eye_ff}
                                                 : {1'b0, eye_ff} - bar_pos;
   assign dist_q   = (eye_dist + (lbs_pkg::EYE_W + 1)'(2)) >> 2;
   assign b_idle   = lbs_pkg::B_W'(lbs_pkg::Q16_ONE) - lbs_pkg::B_W'(dist_q);

   // Voice brightness: bloom in half bars, rounded half up, centre floor
   assign seg2    = {seg_ff, 1'b0};
   assign off_v   = (seg2 >= (lbs_pkg::SEG_W + 1)'(lbs_pkg::BLOOM_OFF_MAX))
                  ? seg2 - (lbs_pkg::SEG_W + 1)'(lbs_pkg::BLOOM_OFF_MAX)
                  : (lbs_pkg::SEG_W + 1)'(lbs_pkg::BLOOM_OFF_MAX) - seg2;
   assign b2      = lbs_pkg::B_W'(e_cur) * lbs_pkg::B_W'(lbs_pkg::BLOOM_SCALE)
                  - (lbs_pkg::B_W'(off_v) << 16);
   assign b2_inc  = b2 + lbs_pkg::B_W'(1);

   always_comb begin
      if (b2 <= 0) begin
         b_voice = '0;
      end else begin
         b_voice = {1'b0, b2_inc[lbs_pkg::B_W-1:1]};
      end
      if (seg_ff == lbs_pkg::SEG_W'(lbs_pkg::CENTRE_SEG)
          && b_voice < $signed(lbs_pkg::B_W'(lbs_pkg::CENTRE_FLOOR))) begin
         b_voice = lbs_pkg::B_W'(lbs_pkg::CENTRE_FLOOR);
      end
      b_sel = voice_ff ? b_voice : b_idle;
      priority if (b_sel < 0) begin
         b_clamp = '0;
      end else if (b_sel > $signed(lbs_pkg::B_W'(lbs_pkg::Q16_ONE))) begin
         b_clamp = lbs_pkg::COEF_W'(lbs_pkg::Q16_ONE);
      end else begin
         b_clamp = b_sel[lbs_pkg::COEF_W-1:0];
      end
   end

   // Envelope update with saturation
   assign env_sum = (lbs_pkg::COEF_W + 3)'(e_cur) + (lbs_pkg::COEF_W + 3)'(env_step);

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, counters and multiplier operands
   always_comb begin
      state_in      = state_ff;
      bar_in        = bar_ff;
      clus_in       = clus_ff;
      seg_in        = seg_ff;
      voice_in      = voice_ff;
      amp_in        = amp_ff;
      up_in         = up_ff;
      mul_a         = b_clamp;
      mul_b         = lbs_pkg::COEF_W'(8'd255 - floor_opacity_ff);
      mul_en        = 1'b0;
      eye_in        = eye_ff;
      down_in       = down_ff;
      eye_we        = 1'b0;
      env_in        = e_cur;
      env_we        = 1'b0;
      env_clear     = 1'b0;
      emit          = 1'b0;
      req_bus.ready = (state_ff == lbs_pkg::S_IDLE);

      unique case (state_ff)
         lbs_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               voice_in = (req_action == lbs_pkg::ACT_MIC)
                       || (req_action == lbs_pkg::ACT_SPEAKER);
               amp_in   = lbs_pkg::SQRT_TABLE[(req_action == lbs_pkg::ACT_MIC)
                                              ? req_bus.mic_level
                                              : req_bus.speaker_level];
               bar_in   = '0;
               clus_in  = '0;
               seg_in   = '0;
               state_in = voice_in ? lbs_pkg::S_TARGET : lbs_pkg::S_EYE;
            end
         end
         lbs_pkg::S_EYE: begin
            eye_we    = 1'b1;
            env_clear = 1'b1;
            priority if (eye_p >= $signed((lbs_pkg::EYE_W + 2)'(lbs_pkg::EYE_LAST))) begin
               eye_in  = lbs_pkg::EYE_W'(lbs_pkg::EYE_LAST);
               down_in = 1'b1;
            end else if (eye_p <= 0) begin
               eye_in  = '0;
               down_in = 1'b0;
            end else begin
               eye_in  = eye_p[lbs_pkg::EYE_W-1:0];
            end
            state_in = lbs_pkg::S_BRIGHT;
         end
         lbs_pkg::S_TARGET: begin
            // amplitude times cluster gain
            mul_a    = amp_ff;
            mul_b    = mid ? centre_gain_ff : outer_gain_ff;
            mul_en   = 1'b1;
            state_in = lbs_pkg::S_STEP;
         end
         lbs_pkg::S_STEP: begin
            // distance to target times attack or decay
            up_in    = (target > e_cur);
            mul_a    = up_in ? target - e_cur : e_cur - target;
            if (up_in) begin
               mul_b = mid ? centre_attack_ff : outer_attack_ff;
            end else begin
               mul_b = mid ? centre_decay_ff : outer_decay_ff;
            end
            mul_en   = 1'b1;
            state_in = lbs_pkg::S_ENV;
         end
         lbs_pkg::S_ENV: begin
            env_we = 1'b1;
            if (up_ff) begin
               env_in = (env_sum > (lbs_pkg::COEF_W + 3)'(lbs_pkg::ENV_MAX))
                      ? lbs_pkg::COEF_W'(lbs_pkg::ENV_MAX)
                      : env_sum[lbs_pkg::COEF_W-1:0];
            end else begin
               env_in = ((lbs_pkg::COEF_W + 2)'(e_cur) < env_step)
                      ? '0
                      : e_cur - env_step[lbs_pkg::COEF_W-1:0];
            end
            state_in = lbs_pkg::S_BRIGHT;
         end
         lbs_pkg::S_BRIGHT: begin
            // clamped brightness times opacity span
            mul_en   = 1'b1;
            state_in = lbs_pkg::S_EMIT;
         end
         lbs_pkg::S_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               if (bar_is_last) begin
                  state_in = lbs_pkg::S_IDLE;
               end else begin
                  bar_in = bar_ff + lbs_pkg::BAR_W'(1);
                  if (voice_ff && seg_ff == lbs_pkg::SEG_W'(lbs_pkg::BARS_PER_CLUSTER - 1)) begin
                     seg_in   = '0;
                     clus_in  = clus_ff + lbs_pkg::CLUSTER_W'(1);
                     state_in = lbs_pkg::S_TARGET;
                  end else begin
                     seg_in   = seg_ff + lbs_pkg::SEG_W'(1);
                     state_in = lbs_pkg::S_BRIGHT;
                  end
               end
            end
         end
         default: state_in = lbs_pkg::S_IDLE;
      endcase
   end

   // Working registers
   always_ff @(posedge clock) begin
      bar_ff   <= bar_in;
      clus_ff  <= clus_in;
      seg_ff   <= seg_in;
      voice_ff <= voice_in;
      amp_ff   <= amp_in;
      up_ff    <= up_in;
      if (mul_en) begin
         mul_ff <= mul_a * mul_b;
      end
   end

   // Eye and envelopes
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff  <= '0;
         down_ff <= 1'b0;
         for (int c = 0; c < lbs_pkg::CLUSTERS; c++) begin
            env_ff[c] <= '0;
         end
      end else begin
         if (eye_we) begin
            eye_ff  <= eye_in;
            down_ff <= down_in;
         end
         if (env_clear) begin
            for (int c = 0; c < lbs_pkg::CLUSTERS; c++) begin
               env_ff[c] <= '0;
            end
         end else if (env_we) begin
            env_ff[clus_ff] <= env_in;
         end
      end
   end

   // Last emitted opacity per bar
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lbs_pkg::BAR_COUNT; i++) begin
            prev_ff[i] <= '0;
         end
      end else if (emit) begin
         prev_ff[bar_ff] <= opa;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_bar_ff     <= lbs_pkg::BAR_INDEX_W'(bar_ff);
         rsp_opa_ff     <= opa;
         rsp_changed_ff <= (opa != prev_ff[bar_ff]);
         rsp_last_ff    <= bar_is_last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.bar_index = rsp_bar_ff;
   assign rsp_bus.opacity   = rsp_opa_ff;
   assign rsp_bus.changed   = rsp_changed_ff;
   assign rsp_bus.last      = rsp_last_ff;

   // any envelope still lit
   always_comb begin
      env_nonzero = 1'b0;
      for (int c = 0; c < lbs_pkg::CLUSTERS; c++) begin
         env_nonzero = env_nonzero | (env_ff[c] != '0);
      end
   end

`ifndef SYNTHESIS
   a_last_on_final_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_bar_ff == lbs_pkg::BAR_INDEX_W'(lbs_pkg::BAR_COUNT - 1))
      else $error("last flag on a bar other than the final one");

   a_eye_in_range: assert property (@(posedge clock) disable iff (reset)
      eye_ff <= lbs_pkg::EYE_W'(lbs_pkg::EYE_LAST))
      else $error("eye beyond the last bar");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> state_ff != lbs_pkg::S_IDLE)
      else $error("sequencer idle right after taking a request");

   a_idle_clears_env: assert property (@(posedge clock) disable iff (reset)
      state_ff == lbs_pkg::S_EYE |=> !env_nonzero)
      else $error("envelope not cleared by an idle frame");

   a_centre_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == lbs_pkg::S_BRIGHT && voice_ff
      && seg_ff == lbs_pkg::SEG_W'(lbs_pkg::CENTRE_SEG)
      |-> mul_a >= lbs_pkg::COEF_W'(lbs_pkg::CENTRE_FLOOR))
      else $error("centre segment below its floor");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the LED bar scanner and level meter.
`timescale 1ns / 1ps

module tb;
   import lbs_pkg::*;

   // The spare action code runs as an idle frame
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
   localparam int STALL_LIMIT  = 2000;
   localparam int END_SETTLE   = 60;
   localparam int RANDOM_FRAMES = 330;
   localparam int PHASES       = 6;

   typedef struct {
      logic [BAR_INDEX_W-1:0] bar_index;
      logic [OPA_W-1:0]       opacity;
      logic                   changed;
      logic                   last;
   } bar_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbs_req_if req_bus ();
   lbs_rsp_if rsp_bus ();
   lbs_csr_if csr_bus ();

   led_bar_scanner_and_level_meter u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // Predicted register copies
   longint scan_step_q, floor_q;
   longint outer_attack_q, centre_attack_q, outer_decay_q, centre_decay_q;
   longint outer_gain_q, centre_gain_q;

   // Predicted block state
   longint           eye_pos;
   logic             eye_down;
   longint           env_level [CLUSTERS];
   logic [OPA_W-1:0] prev_opa [BAR_COUNT];

   bar_result_type expected_bars [$];
   bar_result_type head_bar;

   int  mismatch_count = 0;
   int  frames_sent    = 0;
   int  idle_cycles    = 0;
   int  rsp_stall      = 0;
   bit  req_steady     = 1'b0;
   bit  rsp_steady     = 1'b0;

   // floor of the square root by bisection
   function automatic longint root_floor(input longint x);
      longint lo, hi, mid;
      lo = 0;
      hi = 131072;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= x) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // clamp brightness, map to opacity, queue the bar
   function automatic void queue_bar(input int idx, input longint b);
      bar_result_type r;
      longint         bc, opa;
      bc = (b < 0) ? 0 : ((b > Q16_ONE) ? Q16_ONE : b);
      opa = ((bc * (255 - floor_q) + floor_q * Q16_ONE + Q16_HALF) >> 16) & 255;
      r.bar_index = BAR_INDEX_W'(idx);
      r.opacity   = OPA_W'(opa);
      r.changed   = (OPA_W'(opa) != prev_opa[idx]);
      r.last      = (idx == BAR_COUNT - 1);
      prev_opa[idx] = OPA_W'(opa);
      expected_bars.push_back(r);
   endfunction

   // Expected bars of one frame; updates the predicted state
   function automatic void predict_frame(input logic [ACTION_W-1:0] act,
                                         input logic [LEVEL_W-1:0] mic,
                                         input logic [LEVEL_W-1:0] spk);
      longint p, d, lvl, s, gain, t, e, k, off, b2, b;
      bit     mid;
      if (act == ACT_MIC || act == ACT_SPEAKER) begin
         lvl = (act == ACT_MIC) ? longint'(mic) : longint'(spk);
         s = root_floor((lvl << 32) / 255);
         for (int c = 0; c < CLUSTERS; c++) begin
            mid  = (c == MIDDLE_CLUSTER);
            gain = mid ? centre_gain_q : outer_gain_q;
            t = (s * gain + Q16_HALF) >> 16;
            e = env_level[c];
            if (t > e) begin
               k = mid ? centre_attack_q : outer_attack_q;
               e = e + (((t - e) * k + Q16_HALF) >> 16);
            end else begin
               k = mid ? centre_decay_q : outer_decay_q;
               e = e - (((e - t) * k + Q16_HALF) >> 16);
            end
            if (e < 0) e = 0;
            if (e > ENV_MAX) e = ENV_MAX;
            env_level[c] = e;
            // bloom in half units from the cluster centre
            for (int i = 0; i < BARS_PER_CLUSTER; i++) begin
               off = 2 * i - (BARS_PER_CLUSTER - 1);
               if (off < 0) off = -off;
               b2 = e * (BARS_PER_CLUSTER + 1) - off * Q16_ONE;
               b = (b2 <= 0) ? 0 : ((b2 + 1) >> 1);
               if (i == CENTRE_SEG && b < CENTRE_FLOOR) b = CENTRE_FLOOR;
               queue_bar(c * BARS_PER_CLUSTER + i, b);
            end
         end
      end else begin
         // eye bounce between bar 0 and the last bar
         p = eye_down ? eye_pos - scan_step_q : eye_pos + scan_step_q;
         if (p >= EYE_LAST) begin
            p = EYE_LAST;
            eye_down = 1'b1;
         end else if (p <= 0) begin
            p = 0;
            eye_down = 1'b0;
         end
         eye_pos = p;
         for (int i = 0; i < BAR_COUNT; i++) begin
            d = longint'(i) * Q16_ONE - p;
            if (d < 0) d = -d;
            queue_bar(i, Q16_ONE - ((d + 2) >> 2));
         end
         for (int c = 0; c < CLUSTERS; c++) env_level[c] = 0;
      end
   endfunction

   function automatic void load_reset_state();
      scan_step_q     = SCAN_STEP_RST;
      floor_q         = FLOOR_OPACITY_RST;
      outer_attack_q  = OUTER_ATTACK_RST;
      centre_attack_q = CENTRE_ATTACK_RST;
      outer_decay_q   = OUTER_DECAY_RST;
      centre_decay_q  = CENTRE_DECAY_RST;
      outer_gain_q    = OUTER_GAIN_RST;
      centre_gain_q   = CENTRE_GAIN_RST;
      eye_pos  = 0;
      eye_down = 1'b0;
      for (int c = 0; c < CLUSTERS; c++) env_level[c] = 0;
      for (int i = 0; i < BAR_COUNT; i++) prev_opa[i] = '0;
   endfunction

   // One register write; csr valid stays up for a following write
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_SCAN_STEP:     scan_step_q     = val & 20'hFFFFF;
         REG_FLOOR_OPACITY: floor_q         = val & 8'hFF;
         REG_OUTER_ATTACK:  outer_attack_q  = val & 17'h1FFFF;
         REG_CENTRE_ATTACK: centre_attack_q = val & 17'h1FFFF;
         REG_OUTER_DECAY:   outer_decay_q   = val & 17'h1FFFF;
         REG_CENTRE_DECAY:  centre_decay_q  = val & 17'h1FFFF;
         REG_OUTER_GAIN:    outer_gain_q    = val & 17'h1FFFF;
         REG_CENTRE_GAIN:   centre_gain_q   = val & 17'h1FFFF;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] step, input logic [CSR_DATA_W-1:0] flr,
                             input logic [CSR_DATA_W-1:0] o_att, input logic [CSR_DATA_W-1:0] c_att,
                             input logic [CSR_DATA_W-1:0] o_dec, input logic [CSR_DATA_W-1:0] c_dec,
                             input logic [CSR_DATA_W-1:0] o_gain,
                             input logic [CSR_DATA_W-1:0] c_gain);
      write_reg(REG_SCAN_STEP, step);
      write_reg(REG_FLOOR_OPACITY, flr);
      write_reg(REG_OUTER_ATTACK, o_att);
      write_reg(REG_CENTRE_ATTACK, c_att);
      write_reg(REG_OUTER_DECAY, o_dec);
      write_reg(REG_CENTRE_DECAY, c_dec);
      write_reg(REG_OUTER_GAIN, o_gain);
      write_reg(REG_CENTRE_GAIN, c_gain);
      csr_bus.valid <= 1'b0;
   endtask

   // Random register value in a range, sized to the write data
   function automatic logic [CSR_DATA_W-1:0] rand_data(input int unsigned lo,
                                                       input int unsigned hi);
      return CSR_DATA_W'($urandom_range(hi, lo));
   endfunction

   // Random level byte
   function automatic logic [LEVEL_W-1:0] rand_level();
      return LEVEL_W'($urandom_range(0, 255));
   endfunction

   // Send one frame request with a random lead gap
   task automatic send_frame(input logic [ACTION_W-1:0] act, input logic [LEVEL_W-1:0] mic,
                             input logic [LEVEL_W-1:0] spk);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 15) == 0) req_steady = !req_steady;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= act;
      req_bus.mic_level     <= mic;
      req_bus.speaker_level <= spk;
      do @(posedge clock); while (!req_bus.ready);
      predict_frame(act, mic, spk);
      frames_sent++;
   endtask

   // Block goes idle once every predicted bar has come back
   task automatic wait_frames_done();
      if (req_bus.valid) req_bus.valid <= 1'b0;
      while (expected_bars.size() != 0) @(posedge clock);
   endtask

   // Eye movement from reset and the spare action code
   task automatic test_reset_scan();
      send_frame(ACT_IDLE, 8'h00, 8'hFF);
      send_frame(ACT_IDLE, 8'hFF, 8'h00);
      send_frame(ACT_SPARE, 8'hA5, 8'h5A);
      send_frame(ACT_IDLE, 8'h5A, 8'hA5);
      wait_frames_done();
   endtask

   // Source selection, attack and decay, envelope clear by idle
   task automatic test_voice_sources();
      send_frame(ACT_MIC, 8'hFF, 8'h00);
      send_frame(ACT_SPEAKER, 8'hFF, 8'h00);
      send_frame(ACT_SPEAKER, 8'hFF, 8'h00);
      send_frame(ACT_MIC, 8'h00, 8'hFF);
      send_frame(ACT_SPEAKER, 8'h80, 8'h01);
      send_frame(ACT_IDLE, 8'hFF, 8'hFF);
      wait_frames_done();
   endtask

   // Register extremes at both ends
   task automatic test_config_extremes();
      set_config(20'd917504, 20'd0, 20'd65536, 20'd65536, 20'd65536, 20'd65536,
                 20'd65536, 20'd65536);
      send_frame(ACT_IDLE, 8'h00, 8'h00);
      send_frame(ACT_IDLE, 8'h00, 8'h00);
      send_frame(ACT_IDLE, 8'h00, 8'h00);
      send_frame(ACT_MIC, 8'hFF, 8'h00);
      send_frame(ACT_MIC, 8'h00, 8'hFF);
      wait_frames_done();
      set_config(20'd0, 20'd255, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
      send_frame(ACT_IDLE, 8'h00, 8'h00);
      send_frame(ACT_MIC, 8'hFF, 8'hFF);
      wait_frames_done();
   endtask

   // Coefficients and gains above one: overshoot and saturation
   task automatic test_overshoot();
      set_config(20'd65536, 20'd28, 20'h1FFFF, 20'h1FFFF, 20'h1FFFF, 20'h1FFFF,
                 20'h1FFFF, 20'h1FFFF);
      send_frame(ACT_SPEAKER, 8'h00, 8'hFF);
      send_frame(ACT_SPEAKER, 8'h00, 8'hFF);
      send_frame(ACT_SPEAKER, 8'hFF, 8'h00);
      send_frame(ACT_MIC, 8'h40, 8'h00);
      send_frame(ACT_MIC, 8'hFF, 8'h00);
      wait_frames_done();
   endtask

   // Bursts of voice and idle frames with random levels, some noise
   task automatic test_random_frames();
      int          goal, len, kind;
      logic [ACTION_W-1:0] src;
      logic [LEVEL_W-1:0]  lvl;
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_frames_done();
         if (ph == 0)
            set_config(CSR_DATA_W'(SCAN_STEP_RST), CSR_DATA_W'(FLOOR_OPACITY_RST),
                       CSR_DATA_W'(OUTER_ATTACK_RST), CSR_DATA_W'(CENTRE_ATTACK_RST),
                       CSR_DATA_W'(OUTER_DECAY_RST), CSR_DATA_W'(CENTRE_DECAY_RST),
                       CSR_DATA_W'(OUTER_GAIN_RST), CSR_DATA_W'(CENTRE_GAIN_RST));
         else if (ph == 1)
            set_config(rand_data(327680, 917504), rand_data(0, 255),
                       rand_data(0, 65536), rand_data(0, 65536),
                       rand_data(0, 65536), rand_data(0, 65536),
                       rand_data(0, 65536), rand_data(0, 65536));
         else
            set_config(rand_data(0, 917504), rand_data(0, 255),
                       rand_data(0, 65536), rand_data(0, 65536),
                       rand_data(0, 65536), rand_data(0, 65536),
                       rand_data(0, 65536), rand_data(0, 65536));
         goal = frames_sent + RANDOM_FRAMES / PHASES;
         while (frames_sent < goal) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
               // voice burst from one source, level random or at an extreme
               src = $urandom_range(0, 1) ? ACT_MIC : ACT_SPEAKER;
               len = $urandom_range(3, 12);
               for (int n = 0; n < len && frames_sent < goal; n++) begin
                  case ($urandom_range(0, 3))
                     0: lvl = 8'h00;
                     1: lvl = 8'hFF;
                     default: lvl = rand_level();
                  endcase
                  if (src == ACT_MIC) send_frame(src, lvl, rand_level());
                  else send_frame(src, rand_level(), lvl);
               end
            end else if (kind < 9) begin
               len = $urandom_range(2, 15);
               for (int n = 0; n < len && frames_sent < goal; n++)
                  send_frame(($urandom_range(0, 7) == 0) ? ACT_SPARE : ACT_IDLE,
                             rand_level(), rand_level());
            end else begin
               send_frame(ACTION_W'($urandom_range(0, 3)), rand_level(), rand_level());
            end
         end
      end
      wait_frames_done();
   endtask

   // Response check and random response stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bars.size() == 0) begin
            $error("unexpected response: bar_index %0d opacity %0d",
                   rsp_bus.bar_index, rsp_bus.opacity);
            mismatch_count++;
         end else begin
            head_bar = expected_bars.pop_front();
            if (rsp_bus.bar_index !== head_bar.bar_index) begin
               $error("bar_index: expected %0d, got %0d", head_bar.bar_index, rsp_bus.bar_index);
               mismatch_count++;
            end
            if (rsp_bus.opacity !== head_bar.opacity) begin
               $error("opacity: expected %0d, got %0d", head_bar.opacity, rsp_bus.opacity);
               mismatch_count++;
            end
            if (rsp_bus.changed !== head_bar.changed) begin
               $error("changed: expected %0d, got %0d", head_bar.changed, rsp_bus.changed);
               mismatch_count++;
            end
            if (rsp_bus.last !== head_bar.last) begin
               $error("last: expected %0d, got %0d", head_bar.last, rsp_bus.last);
               mismatch_count++;
            end
         end
         rsp_stall = rsp_steady ? 0 : $urandom_range(0, 4);
         if ($urandom_range(0, 31) == 0) rsp_steady = !rsp_steady;
         rsp_bus.ready <= (rsp_stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= (rsp_stall == 0);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.action        <= ACT_IDLE;
      req_bus.mic_level     <= '0;
      req_bus.speaker_level <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.reg_index     <= REG_SCAN_STEP;
      csr_bus.wdata         <= '0;
      load_reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_scan();
      test_voice_sources();
      test_config_extremes();
      test_overshoot();
      test_random_frames();

      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- led_bar_scanner_and_level_meter.f -----
design/lbs_pkg.sv
design/lbs_if.sv
design/led_bar_scanner_and_level_meter.sv
tb/sv/tb.sv
